FILE: hdl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, register indexes, reset values and the sequencer microcode
// of the clamped PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // Field widths
  localparam int GAIN_W     = 16;
  localparam int ERR_W      = 16;
  localparam int SP_W       = 16;
  localparam int INTEG_W    = 20;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  // Shared multiplier operand widths (signed)
  localparam int A_W = 2 * GAIN_W + 1;
  localparam int B_W = INTEG_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_MIN   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_MAX   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX     = 4'd7;

  // Register reset values
  localparam logic [GAIN_W-1:0]  RST_FILTER_GAIN = 16'd256;
  localparam logic [INTEG_W-1:0] RST_INTEG_MIN   = 20'd0;
  localparam logic [INTEG_W-1:0] RST_INTEG_MAX   = 20'd1000;
  localparam logic [OUT_W-1:0]   RST_OUT_MIN     = 16'd0;
  localparam logic [OUT_W-1:0]   RST_OUT_MAX     = 16'd255;

  // Sequencer
  localparam int STEP_W = 3;

  localparam logic [1:0] A_DGAIN = 2'd0;
  localparam logic [1:0] A_PROD  = 2'd1;
  localparam logic [1:0] A_PGAIN = 2'd2;
  localparam logic [1:0] A_IGAIN = 2'd3;

  localparam logic [1:0] B_FGAIN = 2'd0;
  localparam logic [1:0] B_DIFF  = 2'd1;
  localparam logic [1:0] B_ERR   = 2'd2;
  localparam logic [1:0] B_INTEG = 2'd3;

  localparam logic [1:0] ACC_NOP   = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_ADDSH = 2'd2;

  typedef struct packed {
    logic [1:0] a_sel;
    logic [1:0] b_sel;
    logic       mul_en;
    logic [1:0] acc_op;
    logic       st_upd;    // clamp integrator, form setpoint difference
    logic       shr_en;    // scale accumulator down
    logic       emit;      // clamp and load output register
    logic       wait_in;   // hold until an input transaction
    logic       wait_out;  // hold while the output register is full
    logic       last;      // return to step 0
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '0;
    case (step)
      3'd0: begin
        c.wait_in = 1'b1;
      end
      3'd1: begin
        c.st_upd = 1'b1;
        c.a_sel  = A_DGAIN;
        c.b_sel  = B_FGAIN;
        c.mul_en = 1'b1;
      end
      3'd2: begin
        c.a_sel  = A_PROD;
        c.b_sel  = B_DIFF;
        c.mul_en = 1'b1;
      end
      3'd3: begin
        c.acc_op = ACC_LOAD;
        c.a_sel  = A_PGAIN;
        c.b_sel  = B_ERR;
        c.mul_en = 1'b1;
      end
      3'd4: begin
        c.acc_op = ACC_ADDSH;
        c.a_sel  = A_IGAIN;
        c.b_sel  = B_INTEG;
        c.mul_en = 1'b1;
      end
      3'd5: begin
        c.acc_op = ACC_ADDSH;
      end
      3'd6: begin
        c.shr_en = 1'b1;
      end
      3'd7: begin
        c.emit     = 1'b1;
        c.wait_out = 1'b1;
        c.last     = 1'b1;
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/pidc_cfg_if.sv
// ----------------------------------------------------------------------------
// pidc_cfg_if
// Register write channel: valid/ready with register index and write data.
// ----------------------------------------------------------------------------
interface pidc_cfg_if import pidc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/pidc_in_if.sv
// ----------------------------------------------------------------------------
// pidc_in_if
// Sample channel: valid/ready with the error and setpoint of one tick.
// ----------------------------------------------------------------------------
interface pidc_in_if import pidc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ERR_W-1:0] error_value;
  logic signed [SP_W-1:0]  setpoint;

  modport source (output valid, output error_value, output setpoint, input ready);
  modport sink   (input valid, input error_value, input setpoint, output ready);
endinterface

FILE: hdl/pidc_out_if.sv
// ----------------------------------------------------------------------------
// pidc_out_if
// Result channel: valid/ready with control drive, clamp flag and integrator.
// ----------------------------------------------------------------------------
interface pidc_out_if import pidc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [OUT_W-1:0]   control_value;
  logic                      output_clamped;
  logic signed [INTEG_W-1:0] integrator_value;

  modport source (output valid, output control_value, output output_clamped,
                  output integrator_value, input ready);
  modport sink   (input valid, input control_value, input output_clamped,
                  input integrator_value, output ready);
endinterface

FILE: hdl/pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Fixed-point PID controller with integrator anti-windup and output clamp.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_if : register writes (index 0..7: p, i, d gain, filter gain,
//            integrator min/max, output min/max). Always ready; write only
//            while no sample is in flight. Other indexes are ignored.
//   in_if  : one transaction per sample tick (error, setpoint).
//   out_if : one transaction per sample (control value, clamp flag,
//            integrator after the sample).
// Sequence: a sample runs through an 8-step microcode program on one shared
//   33x20 multiplier (d*f, then *diff, then p*e, then i*I), followed by the
//   scale-down and the clamp. The result is loaded into the output register
//   in the last step; the next sample is taken only back in step 0.
// Stall: the output register holds a result while the receiver stalls; the
//   next sample is still taken and computed, and waits in the last step until
//   the output register frees up.
// Reset: synchronous, active low. Integrator and last setpoint clear to zero,
//   registers return to their reset values, the output register empties.
// ----------------------------------------------------------------------------
module pid_controller_clamped import pidc_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  pidc_cfg_if.sink   cfg_if,
  pidc_in_if.sink    in_if,
  pidc_out_if.source out_if
);

  localparam int MUL_W = A_W + B_W;
  localparam int PI_W  = GAIN_W + 1 + INTEG_W + FRAC_BITS;
  localparam int ACC_W = ((PI_W > MUL_W) ? PI_W : MUL_W) + 2;
  localparam int Y_W   = ACC_W - 2 * FRAC_BITS;

  // Configuration registers
  logic        [GAIN_W-1:0]  p_gain_r, i_gain_r, d_gain_r;
  logic signed [GAIN_W-1:0]  filter_gain_r;
  logic signed [INTEG_W-1:0] integ_min_r, integ_max_r;
  logic signed [OUT_W-1:0]   out_min_r, out_max_r;

  // Sequencer and datapath
  logic [STEP_W-1:0]         pc_r, pc_nxt;
  ctrl_t                     ctrl;
  logic signed [ERR_W-1:0]   e_r;
  logic signed [SP_W-1:0]    sp_r;
  logic signed [SP_W-1:0]    last_sp_r;
  logic signed [SP_W:0]      diff_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W:0]   imin_ext, imax_ext;
  logic signed [INTEG_W-1:0] integ_nxt;
  logic signed [A_W-1:0]     mul_a;
  logic signed [B_W-1:0]     mul_b;
  logic signed [MUL_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   acc_sh;
  logic signed [Y_W-1:0]     y_r;
  logic signed [Y_W-1:0]     omin_ext, omax_ext;
  logic signed [OUT_W-1:0]   ctl_nxt;
  logic                      clamp_nxt;

  // Output register
  logic                      out_valid_r;
  logic signed [OUT_W-1:0]   ctl_r;
  logic                      clamp_r;
  logic signed [INTEG_W-1:0] integ_out_r;

  logic in_fire, cfg_fire, out_blocked, emit_go;

  assign ctrl        = ucode(pc_r);
  assign in_if.ready = ctrl.wait_in;
  assign in_fire     = in_if.valid & in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign cfg_fire    = cfg_if.valid & cfg_if.ready;
  assign out_blocked = out_valid_r & ~out_if.ready;
  assign emit_go     = ctrl.emit & ~out_blocked;

  assign out_if.valid            = out_valid_r;
  assign out_if.control_value    = ctl_r;
  assign out_if.output_clamped   = clamp_r;
  assign out_if.integrator_value = integ_out_r;

  // Step counter with conditional holds
  always_comb begin
    if (ctrl.wait_in && !in_fire) begin
      pc_nxt = pc_r;
    end else if (ctrl.wait_out && out_blocked) begin
      pc_nxt = pc_r;
    end else if (ctrl.last) begin
      pc_nxt = '0;
    end else begin
      pc_nxt = pc_r + STEP_W'(1);
    end
  end

  // Integrator update, upper limit first
  always_comb begin
    isum     = {integ_r[INTEG_W-1], integ_r} + (INTEG_W+1)'(e_r);
    imin_ext = {integ_min_r[INTEG_W-1], integ_min_r};
    imax_ext = {integ_max_r[INTEG_W-1], integ_max_r};
    if (isum > imax_ext) begin
      integ_nxt = integ_max_r;
    end else if (isum < imin_ext) begin
      integ_nxt = integ_min_r;
    end else begin
      integ_nxt = isum[INTEG_W-1:0];
    end
  end

  // Shared multiplier operands
  always_comb begin
    case (ctrl.a_sel)
      A_DGAIN: mul_a = A_W'({1'b0, d_gain_r});
      A_PROD:  mul_a = prod_r[A_W-1:0];
      A_PGAIN: mul_a = A_W'({1'b0, p_gain_r});
      A_IGAIN: mul_a = A_W'({1'b0, i_gain_r});
      default: mul_a = '0;
    endcase
    case (ctrl.b_sel)
      B_FGAIN: mul_b = B_W'(filter_gain_r);
      B_DIFF:  mul_b = B_W'(diff_r);
      B_ERR:   mul_b = B_W'(e_r);
      B_INTEG: mul_b = integ_r;
      default: mul_b = '0;
    endcase
  end

  // Accumulator
  assign prod_ext = {{(ACC_W-MUL_W){prod_r[MUL_W-1]}}, prod_r};
  assign acc_sh   = acc_r >>> (2 * FRAC_BITS);

  always_comb begin
    case (ctrl.acc_op)
      ACC_LOAD:  acc_nxt = prod_ext;
      ACC_ADDSH: acc_nxt = acc_r + (prod_ext <<< FRAC_BITS);
      default:   acc_nxt = acc_r;
    endcase
  end

  // Output clamp, upper limit first
  always_comb begin
    omin_ext = Y_W'(out_min_r);
    omax_ext = Y_W'(out_max_r);
    if (y_r > omax_ext) begin
      ctl_nxt   = out_max_r;
      clamp_nxt = 1'b1;
    end else if (y_r < omin_ext) begin
      ctl_nxt   = out_min_r;
      clamp_nxt = 1'b1;
    end else begin
      ctl_nxt   = y_r[OUT_W-1:0];
      clamp_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r          <= '0;
      out_valid_r   <= 1'b0;
      integ_r       <= '0;
      last_sp_r     <= '0;
      p_gain_r      <= '0;
      i_gain_r      <= '0;
      d_gain_r      <= '0;
      filter_gain_r <= RST_FILTER_GAIN;
      integ_min_r   <= RST_INTEG_MIN;
      integ_max_r   <= RST_INTEG_MAX;
      out_min_r     <= RST_OUT_MIN;
      out_max_r     <= RST_OUT_MAX;
    end else begin
      pc_r <= pc_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (ctrl.st_upd) begin
        integ_r   <= integ_nxt;
        last_sp_r <= sp_r;
      end
      if (cfg_fire) begin
        case (cfg_if.index)
          REG_P_GAIN:      p_gain_r      <= cfg_if.data[GAIN_W-1:0];
          REG_I_GAIN:      i_gain_r      <= cfg_if.data[GAIN_W-1:0];
          REG_D_GAIN:      d_gain_r      <= cfg_if.data[GAIN_W-1:0];
          REG_FILTER_GAIN: filter_gain_r <= cfg_if.data[GAIN_W-1:0];
          REG_INTEG_MIN:   integ_min_r   <= cfg_if.data[INTEG_W-1:0];
          REG_INTEG_MAX:   integ_max_r   <= cfg_if.data[INTEG_W-1:0];
          REG_OUT_MIN:     out_min_r     <= cfg_if.data[OUT_W-1:0];
          REG_OUT_MAX:     out_max_r     <= cfg_if.data[OUT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      e_r  <= in_if.error_value;
      sp_r <= in_if.setpoint;
    end
    if (ctrl.st_upd) begin
      diff_r <= {sp_r[SP_W-1], sp_r} - {last_sp_r[SP_W-1], last_sp_r};
    end
    if (ctrl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    acc_r <= acc_nxt;
    if (ctrl.shr_en) begin
      y_r <= acc_sh[Y_W-1:0];
    end
    if (emit_go) begin
      ctl_r       <= ctl_nxt;
      clamp_r     <= clamp_nxt;
      integ_out_r <= integ_r;
    end
  end

  // Checks
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pc_r == STEP_W'(1))
    else $error("sequencer did not start after input transaction");

  a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == STEP_W'(2) && integ_min_r <= integ_max_r) |->
      (integ_r >= integ_min_r && integ_r <= integ_max_r))
    else $error("integrator outside its limits");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_min_r <= out_max_r) |->
      (ctl_r >= out_min_r && ctl_r <= out_max_r))
    else $error("control value outside output limits");

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (out_valid_r && pc_r == '0))
    else $error("result not registered at end of program");

endmodule

FILE: sim/pidc_drive_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pidc_drive_checker
// Watches the register, sample and drive channels of the clamped PID
// controller. Keeps its own copy of the gains, limits, integrator and last
// setpoint, predicts the drive of every accepted sample and compares each
// accepted drive transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module pidc_drive_checker import pidc_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  pidc_cfg_if  cfg_mon,
  pidc_in_if   smp_mon,
  pidc_out_if  drv_mon,
  output int   errors,
  output int   pending,
  output int   n_checked,
  output int   n_out_clamp,
  output int   n_int_clamp
);

  typedef struct packed {
    logic signed [OUT_W-1:0]   control;
    logic                      clamped;
    logic signed [INTEG_W-1:0] integ;
  } drive_t;

  localparam int MAX_PRINTED = 20;

  logic        [GAIN_W-1:0]  kp, ki, kd;
  logic signed [GAIN_W-1:0]  kf;
  logic signed [INTEG_W-1:0] integ_lo, integ_hi, integ;
  logic signed [OUT_W-1:0]   drive_lo, drive_hi;
  logic signed [SP_W-1:0]    last_sp;
  drive_t                    expected_drive[$];
  drive_t                    want;

  task automatic report(input string msg);
    if (errors < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    errors++;
  endtask

  // Advance the integrator and setpoint history by one sample tick and predict the drive.
  function automatic drive_t predict_drive(input logic signed [ERR_W-1:0] e,
                                           input logic signed [SP_W-1:0]  sp);
    drive_t r;
    longint acc;
    longint diff;
    longint total;
    longint y;
    acc = longint'(integ) + longint'(e);
    // upper limit wins when the limits are crossed
    if (acc > integ_hi) begin
      acc = integ_hi;
      n_int_clamp++;
    end else if (acc < integ_lo) begin
      acc = integ_lo;
      n_int_clamp++;
    end
    integ   = acc[INTEG_W-1:0];
    diff    = longint'(sp) - longint'(last_sp);
    last_sp = sp;
    total = ((longint'(kp) * longint'(e) + longint'(ki) * acc) <<< FRAC_BITS)
            + longint'(kd) * longint'(kf) * diff;
    // arithmetic shift rounds toward minus infinity
    y = total >>> (2 * FRAC_BITS);
    r.clamped = 1'b1;
    if (y > drive_hi) begin
      y = drive_hi;
    end else if (y < drive_lo) begin
      y = drive_lo;
    end else begin
      r.clamped = 1'b0;
    end
    if (r.clamped) begin
      n_out_clamp++;
    end
    r.control = y[OUT_W-1:0];
    r.integ   = integ;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      kp          = '0;
      ki          = '0;
      kd          = '0;
      kf          = RST_FILTER_GAIN;
      integ_lo    = RST_INTEG_MIN;
      integ_hi    = RST_INTEG_MAX;
      drive_lo    = RST_OUT_MIN;
      drive_hi    = RST_OUT_MAX;
      integ       = '0;
      last_sp     = '0;
      errors      = 0;
      n_checked   = 0;
      n_out_clamp = 0;
      n_int_clamp = 0;
      expected_drive.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_P_GAIN:      kp       = cfg_mon.data[GAIN_W-1:0];
          REG_I_GAIN:      ki       = cfg_mon.data[GAIN_W-1:0];
          REG_D_GAIN:      kd       = cfg_mon.data[GAIN_W-1:0];
          REG_FILTER_GAIN: kf       = cfg_mon.data[GAIN_W-1:0];
          REG_INTEG_MIN:   integ_lo = cfg_mon.data[INTEG_W-1:0];
          REG_INTEG_MAX:   integ_hi = cfg_mon.data[INTEG_W-1:0];
          REG_OUT_MIN:     drive_lo = cfg_mon.data[OUT_W-1:0];
          REG_OUT_MAX:     drive_hi = cfg_mon.data[OUT_W-1:0];
          default: ;
        endcase
      end
      // compare before pushing: a drive never belongs to a sample of this edge
      if (drv_mon.valid && drv_mon.ready) begin
        if (expected_drive.size() == 0) begin
          report($sformatf("drive transaction with nothing expected (control %0d)",
                           drv_mon.control_value));
        end else begin
          want = expected_drive.pop_front();
          if (drv_mon.control_value !== want.control) begin
            report($sformatf("result %0d control_value got %0d expected %0d",
                             n_checked, drv_mon.control_value, want.control));
          end
          if (drv_mon.output_clamped !== want.clamped) begin
            report($sformatf("result %0d output_clamped got %0b expected %0b",
                             n_checked, drv_mon.output_clamped, want.clamped));
          end
          if (drv_mon.integrator_value !== want.integ) begin
            report($sformatf("result %0d integrator_value got %0d expected %0d",
                             n_checked, drv_mon.integrator_value, want.integ));
          end
          n_checked++;
        end
      end
      if (smp_mon.valid && smp_mon.ready) begin
        expected_drive.push_back(predict_drive(smp_mon.error_value, smp_mon.setpoint));
      end
    end
    pending = expected_drive.size();
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the clamped PID controller: a directed run over reset values,
// field extremes, crossed limits and negative filter gain, then random
// register settings with random sample streams and random idling on both
// channels. Checking is done by pidc_drive_checker.
// ----------------------------------------------------------------------------
module testbench import pidc_pkg::*; ();

  localparam int FRAC_BITS         = 8;
  localparam int CYCLES_PER_SAMPLE = 8;
  localparam int RAND_SETTINGS     = 12;
  localparam int ITEMS_PER_SETTING = 150;
  localparam int WATCHDOG_LIMIT    = 1000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  localparam int GAIN_MAX  = 65535;
  localparam int S16_MIN   = -32768;
  localparam int S16_MAX   = 32767;
  localparam int S20_MIN   = -524288;
  localparam int S20_MAX   = 524287;
  localparam int UNITY     = 256;

  logic clk;
  logic rst_n = 1'b0;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;
  int   settings = 0;
  int   writes   = 0;
  int   stuck    = 0;

  int errors, pending, n_checked, n_out_clamp, n_int_clamp;

  pidc_cfg_if cfg_bus ();
  pidc_in_if  smp_bus ();
  pidc_out_if drv_bus ();

  pid_controller_clamped #(
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_bus),
    .in_if  (smp_bus),
    .out_if (drv_bus)
  );

  pidc_drive_checker #(
    .FRAC_BITS (FRAC_BITS)
  ) i_drive_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_mon     (cfg_bus),
    .smp_mon     (smp_bus),
    .drv_mon     (drv_bus),
    .errors      (errors),
    .pending     (pending),
    .n_checked   (n_checked),
    .n_out_clamp (n_out_clamp),
    .n_int_clamp (n_int_clamp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int rand_in(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // 16-bit registers ignore the top data bits: fill them with noise.
  function automatic logic [CFG_DATA_W-1:0] pad16(input int v);
    logic [CFG_DATA_W-1:0] r;
    r       = CFG_DATA_W'($urandom);
    r[15:0] = v[15:0];
    return r;
  endfunction

  function automatic int pick_gain();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return GAIN_MAX;
      2:       return rand_in(0, 512);
      3:       return UNITY;
      default: return rand_in(0, GAIN_MAX);
    endcase
  endfunction

  task automatic pick_limits(input int lo_bound, input int hi_bound,
                             output int lo, output int hi);
    int a;
    int b;
    a = rand_in(lo_bound, hi_bound);
    b = rand_in(lo_bound, hi_bound);
    case ($urandom_range(0, 4))
      0: begin
        lo = lo_bound;
        hi = hi_bound;
      end
      1: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      2: begin
        // crossed
        lo = (a < b) ? b : a;
        hi = (a < b) ? a : b;
      end
      3: begin
        lo = rand_in(-2000, 0);
        hi = rand_in(0, 2000);
      end
      default: begin
        lo = a;
        hi = b;
      end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    @(negedge clk);
    cfg_bus.valid = 1'b0;
    writes++;
  endtask

  // Hold the sample channel until every predicted drive has come back.
  task automatic drain();
    smp_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apply_setting(input int p, input int i, input int d, input int f,
                               input int ilo, input int ihi,
                               input int olo, input int ohi);
    drain();
    write_reg(REG_P_GAIN,      pad16(p));
    write_reg(REG_I_GAIN,      pad16(i));
    write_reg(REG_D_GAIN,      pad16(d));
    write_reg(REG_FILTER_GAIN, pad16(f));
    write_reg(REG_INTEG_MIN,   CFG_DATA_W'(ilo));
    write_reg(REG_INTEG_MAX,   CFG_DATA_W'(ihi));
    write_reg(REG_OUT_MIN,     pad16(olo));
    write_reg(REG_OUT_MAX,     pad16(ohi));
    settings++;
  endtask

  task automatic send_sample(input int e_val, input int sp_val);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      smp_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp_bus.valid       = 1'b1;
    smp_bus.error_value = ERR_W'(e_val);
    smp_bus.setpoint    = SP_W'(sp_val);
    do @(posedge clk); while (!(smp_bus.valid && smp_bus.ready));
    @(negedge clk);
  endtask

  // drive receiver: random stall before each transaction unless rx_quiet is set
  initial begin : drive_sink
    int stall;
    drv_bus.ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        drv_bus.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      drv_bus.ready = 1'b1;
      do @(posedge clk); while (!(drv_bus.valid && drv_bus.ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((cfg_bus.valid && cfg_bus.ready) || (smp_bus.valid && smp_bus.ready) ||
        (drv_bus.valid && drv_bus.ready)) begin
      stuck = 0;
    end else begin
      stuck++;
    end
    if (stuck >= WATCHDOG_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles, %0d drives outstanding",
               $realtime, stuck, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int ilo, ihi, olo, ohi, f;
    logic signed [ERR_W-1:0] e;
    logic signed [SP_W-1:0]  sp;

    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = '0;
    cfg_bus.data        = '0;
    smp_bus.valid       = 1'b0;
    smp_bus.error_value = '0;
    smp_bus.setpoint    = '0;
    sp                  = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values: zero gains, integrator held in [0, 1000]
    send_sample(500, 10);
    send_sample(800, -5);
    send_sample(S16_MIN, 0);

    // unity gains, widest limits, field extremes and full setpoint swings
    apply_setting(UNITY, UNITY, UNITY, UNITY, S20_MIN, S20_MAX, S16_MIN, S16_MAX);
    send_sample(S16_MAX, S16_MAX);
    send_sample(S16_MIN, S16_MIN);
    send_sample(0, 0);
    send_sample(-1, S16_MAX);
    send_sample(1, S16_MIN);
    send_sample(-300, -1);

    // largest gains, negative filter, crossed limits, writes to unused indexes
    apply_setting(GAIN_MAX, GAIN_MAX, GAIN_MAX, S16_MIN, 50, -50, 100, -100);
    write_reg(REG_UNUSED_LO, CFG_DATA_W'($urandom));
    write_reg(REG_UNUSED_HI, CFG_DATA_W'($urandom));
    send_sample(S16_MAX, S16_MIN);
    send_sample(S16_MIN, S16_MAX);
    send_sample(0, 0);
    send_sample(7, 7);

    // derivative only, largest positive filter
    apply_setting(0, 0, GAIN_MAX, S16_MAX, S20_MIN, S20_MAX, S16_MIN, S16_MAX);
    send_sample(0, 1);
    send_sample(0, 0);
    send_sample(0, -1);
    send_sample(S16_MAX, S16_MAX);

    for (int ph = 0; ph < RAND_SETTINGS; ph++) begin
      pick_limits(S20_MIN, S20_MAX, ilo, ihi);
      pick_limits(S16_MIN, S16_MAX, olo, ohi);
      case ($urandom_range(0, 4))
        0:       f = UNITY;
        1:       f = S16_MIN;
        2:       f = S16_MAX;
        3:       f = rand_in(-512, 512);
        default: f = rand_in(S16_MIN, S16_MAX);
      endcase
      apply_setting(pick_gain(), pick_gain(), pick_gain(), f, ilo, ihi, olo, ohi);
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_UNUSED_LO + CFG_IDX_W'($urandom_range(0, 7)),
                  CFG_DATA_W'($urandom));
      end
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      repeat (ITEMS_PER_SETTING) begin
        case ($urandom_range(0, 5))
          0, 1:    e = ERR_W'(rand_in(S16_MIN, S16_MAX));
          2, 3:    e = ERR_W'(rand_in(-300, 300));
          4:       e = ($urandom_range(0, 1) != 0) ? ERR_W'(S16_MAX) : ERR_W'(S16_MIN);
          default: e = '0;
        endcase
        case ($urandom_range(0, 4))
          0:       sp = sp;
          1:       sp = sp + SP_W'(rand_in(-50, 50));
          2, 3:    sp = SP_W'(rand_in(S16_MIN, S16_MAX));
          default: sp = ($urandom_range(0, 1) != 0) ? SP_W'(S16_MAX) : SP_W'(S16_MIN);
        endcase
        send_sample(e, sp);
      end
    end

    drain();
    tx_quiet = 1'b0;
    // catch any stray drive after the last expected one
    repeat (2 * CYCLES_PER_SAMPLE) @(negedge clk);

    $display("Checked %0d drives under %0d register settings (%0d register writes).",
             n_checked, settings, writes);
    $display("Output limit applied %0d times, integrator limit %0d times.",
             n_out_clamp, n_int_clamp);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: pid_controller_clamped.f
hdl/pidc_pkg.sv
hdl/pidc_cfg_if.sv
hdl/pidc_in_if.sv
hdl/pidc_out_if.sv
hdl/pid_controller_clamped.sv
sim/pidc_drive_checker.sv
sim/testbench.sv
